### rtl/antialiased_line_generator_top_assert.svh
// Assertion macros for the line generator checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ANTIALIASED_LINE_GENERATOR_TOP_ASSERT_SVH
`define ANTIALIASED_LINE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define ALG_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALG_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/alg_pkg.sv
// Shared constants, types and codes for the antialiased line generator.
// No dependencies; used by the interfaces, controller, datapath and top.
package alg_pkg;

  localparam int COORD_BITS = 12;
  localparam int PX_W       = COORD_BITS + 2;   // signed x, may reach -1 or 2^COORD_BITS
  localparam int PY_W       = COORD_BITS + 1;
  localparam int COLOR_W    = 9;
  localparam int BASE_W     = 8;
  localparam int LEVELS_W   = 9;
  localparam int IBITS_W    = 4;
  localparam int ACC_BITS   = 16;
  localparam int SH_W       = $clog2(ACC_BITS) + 1;
  localparam int DIV_CNT_W  = $clog2(ACC_BITS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_BITS = 2'd2;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // what the last accepted word left to emit
  typedef enum logic [2:0] {
    K_NONE,
    K_FIRST,
    K_SINGLE,
    K_END,
    K_PAIR
  } emit_kind_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit0;
    logic emit1;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    emit_kind_t kind;
    logic       div_pend;
    logic       div_last;
  } dp_status_t;

  typedef struct packed {
    logic signed [PX_W-1:0]    x;
    logic        [PY_W-1:0]    y;
    logic        [COLOR_W-1:0] color;
    logic                      last;
    logic                      done;
  } pixel_t;

endpackage

### rtl/alg_if.sv
// Valid/ready channel interfaces for the line generator input and result words.
// Depends on alg_pkg for field widths.
interface alg_in_if;
  import alg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, output ready);
  modport monitor (input valid, ready, operation, start_x, start_y, end_x, end_y);
endinterface

interface alg_out_if;
  import alg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [PX_W-1:0]    pixel_x;
  logic        [PY_W-1:0]    pixel_y;
  logic        [COLOR_W-1:0] color;
  logic                      last_of_step;
  logic                      line_done;

  modport source (output valid, pixel_x, pixel_y, color, last_of_step, line_done,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, color, last_of_step, line_done,
                output ready);
  modport monitor (input valid, ready, pixel_x, pixel_y, color, last_of_step, line_done);
endinterface

### rtl/alg_ctrl.sv
// Controller FSM of the line generator: input handshake, result register
// handshake and sequencing of the set-up divider. Depends on alg_pkg.
module alg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output alg_pkg::dp_cmd_t    cmd,
  input  alg_pkg::dp_status_t status
);
  import alg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT0,
    S_EMIT1,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = (in_operation == OP_LOAD);
          cmd.step  = (in_operation == OP_STEP);
          state_nxt = S_EMIT0;
        end
      end
      S_EMIT0: begin
        if (status.kind == K_NONE) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          cmd.emit0     = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.kind == K_PAIR) begin
            state_nxt = S_EMIT1;
          end else if (status.div_pend) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          cmd.emit1     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/alg_datapath.sv
// Datapath of the line generator: line state, configuration registers,
// radix-2 restoring divider for the error step and the result word register.
// Depends on alg_pkg.
module alg_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  alg_pkg::dp_cmd_t                      cmd,
  output alg_pkg::dp_status_t                   status,
  input  logic                                  cfg_we,
  input  logic [alg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [alg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [alg_pkg::COORD_BITS-1:0]        start_x,
  input  logic [alg_pkg::COORD_BITS-1:0]        start_y,
  input  logic [alg_pkg::COORD_BITS-1:0]        end_x,
  input  logic [alg_pkg::COORD_BITS-1:0]        end_y,
  output alg_pkg::pixel_t                       pixel
);
  import alg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_BITS - 1);

  typedef enum logic [2:0] {
    M_IDLE,
    M_HORIZ,
    M_VERT,
    M_DIAG,
    M_YMAJ,
    M_XMAJ
  } mode_t;

  // line state
  mode_t                mode_r, mode_nxt;
  logic [CB-1:0]        cur_x_r, cur_x_nxt;
  logic [CB-1:0]        cur_y_r, cur_y_nxt;
  logic [CB-1:0]        final_x_r, final_x_nxt;
  logic [CB-1:0]        final_y_r, final_y_nxt;
  logic                 x_neg_r, x_neg_nxt;
  logic [CB-1:0]        steps_r, steps_nxt;
  logic [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic [ACC_BITS-1:0]  estep_r, estep_nxt;
  emit_kind_t           kind_r, kind_nxt;
  logic                 done_r, done_nxt;

  // divider
  logic                 div_pend_r, div_pend_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CB-1:0]        rem_r, rem_nxt;
  logic [CB-1:0]        den_r, den_nxt;

  // configuration
  logic [BASE_W-1:0]    base_r;
  logic [LEVELS_W-1:0]  levels_r;
  logic [IBITS_W-1:0]   ibits_r;

  pixel_t               pix_r, pix_nxt;

  // load set-up
  logic          swap;
  logic [CB-1:0] lx0, ly0, lx1, ly1;
  logic          ld_neg;
  logic [CB-1:0] ld_dx, ld_dy;
  mode_t         ld_mode;

  // step arithmetic
  logic [CB-1:0]       x_adv, y_adv, steps_dec;
  logic [ACC_BITS-1:0] acc_sum;
  logic                wrapped;
  logic [CB:0]         rem2;
  logic                rem_ge;

  // pixel formation
  logic [SH_W-1:0]           sh;
  logic [ACC_BITS-1:0]       w_full;
  logic [COLOR_W-1:0]        wsel, lvl_mask, base9;
  logic signed [PX_W-1:0]    px_cur, px_step;

  assign swap   = start_y > end_y;
  assign lx0    = swap ? end_x : start_x;
  assign ly0    = swap ? end_y : start_y;
  assign lx1    = swap ? start_x : end_x;
  assign ly1    = swap ? start_y : end_y;
  assign ld_neg = lx1 < lx0;
  assign ld_dx  = ld_neg ? (lx0 - lx1) : (lx1 - lx0);
  assign ld_dy  = ly1 - ly0;

  always_comb begin
    if (ld_dx == '0 && ld_dy == '0) begin
      ld_mode = M_IDLE;
    end else if (ld_dy == '0) begin
      ld_mode = M_HORIZ;
    end else if (ld_dx == '0) begin
      ld_mode = M_VERT;
    end else if (ld_dx == ld_dy) begin
      ld_mode = M_DIAG;
    end else if (ld_dy > ld_dx) begin
      ld_mode = M_YMAJ;
    end else begin
      ld_mode = M_XMAJ;
    end
  end

  assign x_adv     = x_neg_r ? (cur_x_r - CB'(1)) : (cur_x_r + CB'(1));
  assign y_adv     = cur_y_r + CB'(1);
  assign steps_dec = steps_r - CB'(1);
  assign acc_sum   = acc_r + estep_r;
  assign wrapped   = acc_sum <= acc_r;
  assign rem2      = {rem_r, 1'b0};
  assign rem_ge    = rem2 >= {1'b0, den_r};

  always_comb begin
    mode_nxt     = mode_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    final_x_nxt  = final_x_r;
    final_y_nxt  = final_y_r;
    x_neg_nxt    = x_neg_r;
    steps_nxt    = steps_r;
    acc_nxt      = acc_r;
    estep_nxt    = estep_r;
    kind_nxt     = kind_r;
    done_nxt     = done_r;
    div_pend_nxt = div_pend_r;
    div_cnt_nxt  = div_cnt_r;
    rem_nxt      = rem_r;
    den_nxt      = den_r;
    if (cmd.load) begin
      mode_nxt     = ld_mode;
      cur_x_nxt    = lx0;
      cur_y_nxt    = ly0;
      final_x_nxt  = lx1;
      final_y_nxt  = ly1;
      x_neg_nxt    = ld_neg;
      steps_nxt    = (ld_mode == M_HORIZ || ld_mode == M_XMAJ) ? ld_dx : ld_dy;
      acc_nxt      = '0;
      estep_nxt    = '0;
      kind_nxt     = K_FIRST;
      done_nxt     = (ld_mode == M_IDLE);
      div_pend_nxt = (ld_mode == M_YMAJ || ld_mode == M_XMAJ);
      div_cnt_nxt  = '0;
      rem_nxt      = (ld_mode == M_YMAJ) ? ld_dx : ld_dy;
      den_nxt      = (ld_mode == M_YMAJ) ? ld_dy : ld_dx;
    end else if (cmd.step) begin
      if (mode_r == M_IDLE || steps_r == '0) begin
        mode_nxt = M_IDLE;
        kind_nxt = K_NONE;
      end else if (mode_r == M_HORIZ || mode_r == M_VERT || mode_r == M_DIAG) begin
        if (mode_r != M_VERT) begin
          cur_x_nxt = x_adv;
        end
        if (mode_r != M_HORIZ) begin
          cur_y_nxt = y_adv;
        end
        steps_nxt = steps_dec;
        done_nxt  = (steps_dec == '0);
        kind_nxt  = K_SINGLE;
        if (steps_dec == '0) begin
          mode_nxt = M_IDLE;
        end
      end else if (steps_r == CB'(1)) begin
        // closing step of a weighted line: end pixel only
        steps_nxt = '0;
        mode_nxt  = M_IDLE;
        kind_nxt  = K_END;
      end else begin
        acc_nxt   = acc_sum;
        steps_nxt = steps_dec;
        kind_nxt  = K_PAIR;
        if (mode_r == M_YMAJ) begin
          cur_y_nxt = y_adv;
          if (wrapped) begin
            cur_x_nxt = x_adv;
          end
        end else begin
          cur_x_nxt = x_adv;
          if (wrapped) begin
            cur_y_nxt = y_adv;
          end
        end
      end
    end else if (cmd.div_step) begin
      rem_nxt     = rem_ge ? CB'(rem2 - {1'b0, den_r}) : rem2[CB-1:0];
      estep_nxt   = {estep_r[ACC_BITS-2:0], rem_ge};
      div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
      if (div_cnt_r == DIV_LAST) begin
        div_pend_nxt = 1'b0;
      end
    end
  end

  // weighting: top intensity bits of the accumulator
  assign sh       = SH_W'(ACC_BITS) - SH_W'(ibits_r);
  assign w_full   = acc_r >> sh;
  assign wsel     = (ibits_r == '0) ? '0 : w_full[COLOR_W-1:0];
  assign lvl_mask = levels_r - LEVELS_W'(1);
  assign base9    = COLOR_W'(base_r);
  assign px_cur   = $signed({2'b00, cur_x_r});
  assign px_step  = x_neg_r ? {PX_W{1'b1}} : PX_W'(1);

  always_comb begin
    pix_nxt = pix_r;
    if (cmd.emit0) begin
      case (kind_r)
        K_PAIR: begin
          pix_nxt.x     = px_cur;
          pix_nxt.y     = PY_W'(cur_y_r);
          pix_nxt.color = base9 + wsel;
          pix_nxt.last  = 1'b0;
          pix_nxt.done  = 1'b0;
        end
        K_END: begin
          pix_nxt.x     = $signed({2'b00, final_x_r});
          pix_nxt.y     = PY_W'(final_y_r);
          pix_nxt.color = base9;
          pix_nxt.last  = 1'b1;
          pix_nxt.done  = 1'b1;
        end
        default: begin
          pix_nxt.x     = px_cur;
          pix_nxt.y     = PY_W'(cur_y_r);
          pix_nxt.color = base9;
          pix_nxt.last  = 1'b1;
          pix_nxt.done  = done_r;
        end
      endcase
    end else if (cmd.emit1) begin
      pix_nxt.x     = (mode_r == M_YMAJ) ? (px_cur + px_step) : px_cur;
      pix_nxt.y     = (mode_r == M_YMAJ) ? PY_W'(cur_y_r) : (PY_W'(cur_y_r) + PY_W'(1));
      pix_nxt.color = base9 + (wsel ^ lvl_mask);
      pix_nxt.last  = 1'b1;
      pix_nxt.done  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      kind_r     <= K_NONE;
      div_pend_r <= 1'b0;
      div_cnt_r  <= '0;
      base_r     <= '0;
      levels_r   <= LEVELS_W'(256);
      ibits_r    <= IBITS_W'(8);
    end else begin
      mode_r     <= mode_nxt;
      kind_r     <= kind_nxt;
      div_pend_r <= div_pend_nxt;
      div_cnt_r  <= div_cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_COLOR:     base_r   <= cfg_wdata[BASE_W-1:0];
          CFG_NUM_LEVELS:     levels_r <= cfg_wdata[LEVELS_W-1:0];
          CFG_INTENSITY_BITS: ibits_r  <= cfg_wdata[IBITS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    final_x_r <= final_x_nxt;
    final_y_r <= final_y_nxt;
    x_neg_r   <= x_neg_nxt;
    steps_r   <= steps_nxt;
    acc_r     <= acc_nxt;
    estep_r   <= estep_nxt;
    done_r    <= done_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    pix_r     <= pix_nxt;
  end

  assign status.kind     = kind_r;
  assign status.div_pend = div_pend_r;
  assign status.div_last = (div_cnt_r == DIV_LAST);
  assign pixel           = pix_r;

endmodule

### rtl/antialiased_line_generator_top.sv
// Top level of the antialiased line generator.
// Depends on alg_pkg, alg_if (channel interfaces), alg_ctrl and alg_datapath.
//
// Usage:
//   in_word  : valid/ready input channel. operation = load takes two endpoints,
//              operation = step advances the running line by one position.
//   out_word : valid/ready result channel, one pixel per word. A weighted-line
//              step gives two words, its closing step one; last_of_step marks
//              the final word of each input word, line_done a line's end pixel.
//   cfg_*    : write-only register port (base color, levels, intensity bits),
//              written by the user only while the block is idle; not enforced.
// Timing: results sit in a single output register; the first word of an input
//   word is registered there after the line state is updated and once the
//   register is free. After a load's first pixel, a weighted line runs the
//   16-bit error step divider (one quotient bit per cycle). A step gives one
//   result, none or a pair. in_word.ready is high only between words.
// Reset: synchronous, active low. The line goes idle, the result register
//   empties and the registers take their defaults (base 0, 256 levels, 8 bits).
// Stall: while out_word.ready is low the held word stays put and the
//   controller waits; nothing is dropped.
module antialiased_line_generator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  alg_in_if.sink                         in_word,
  alg_out_if.source                      out_word,
  input  logic                           cfg_we,
  input  logic [alg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  pixel_t     pixel;
  logic       in_ready;
  logic       out_valid;

  alg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_word.valid),
    .in_operation (in_word.operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_word.ready),
    .cmd          (cmd),
    .status       (status)
  );

  alg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start_x   (in_word.start_x),
    .start_y   (in_word.start_y),
    .end_x     (in_word.end_x),
    .end_y     (in_word.end_y),
    .pixel     (pixel)
  );

  assign in_word.ready         = in_ready;
  assign out_word.valid        = out_valid;
  assign out_word.pixel_x      = pixel.x;
  assign out_word.pixel_y      = pixel.y;
  assign out_word.color        = pixel.color;
  assign out_word.last_of_step = pixel.last;
  assign out_word.line_done    = pixel.done;

endmodule

### rtl/alg_checker.sv
// Port-level checker for the line generator, bound to the top level.
// Depends on alg_pkg widths and the assertion macro header.
`include "antialiased_line_generator_top_assert.svh"

module alg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [alg_pkg::PX_W-1:0]     out_pixel_x,
  input logic [alg_pkg::COLOR_W-1:0]  out_color,
  input logic                         out_last_of_step,
  input logic                         out_line_done
);

  // held result word keeps its payload
  `ALG_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_x) && $stable(out_color), "stalled result word changed")

  // second pixel of a pair follows right behind the first
  `ALG_AST_NXT(a_pair_second, out_valid && out_ready && !out_last_of_step, out_valid && out_last_of_step, "pair second pixel missing")

  // the pixel that ends a line closes its input word
  `ALG_AST_IMP(a_done_is_last, out_valid && out_line_done, out_last_of_step, "line_done without last_of_step")

  // no new input word while a pair is half delivered
  `ALG_AST_IMP(a_no_split_pair, in_valid && in_ready, !(out_valid && !out_last_of_step), "input accepted mid pair")

endmodule

bind antialiased_line_generator_top alg_checker u_alg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_word.valid),
  .in_ready         (in_word.ready),
  .out_valid        (out_word.valid),
  .out_ready        (out_word.ready),
  .out_pixel_x      (out_word.pixel_x),
  .out_color        (out_word.color),
  .out_last_of_step (out_word.last_of_step),
  .out_line_done    (out_word.line_done)
);
